[hdl/ptw_pkg.sv]
// types and constants shared by the page table walker
// no dependencies
`default_nettype none

package ptw_pkg;

    localparam int PAGE_OFFSET_BITS = 12;
    localparam int VIRTUAL_BITS     = 48;
    localparam int PA_BITS          = 52;
    localparam int ENTRY_BITS       = 64;
    localparam int INDEX_BITS       = 9;
    localparam int ENTRY_SIZE_BITS  = 3;
    localparam int FRAME_HI         = 35;
    localparam int BASE_LOW_BITS    = 4;
    localparam int PAGE_1G_BITS     = 30;
    localparam int PAGE_2M_BITS     = 21;
    localparam int PRESENT_BIT      = 0;
    localparam int LARGE_BIT        = 7;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_DATA  = 1'b1;
    localparam logic RES_READ   = 1'b0;
    localparam logic RES_DONE   = 1'b1;

    typedef enum logic [4:0] {
        LVL_IDLE = 5'b00001,
        LVL_1    = 5'b00010,
        LVL_2    = 5'b00100,
        LVL_3    = 5'b01000,
        LVL_4    = 5'b10000
    } t_level;

    typedef struct packed {
        logic                    kind;
        logic [PA_BITS-1:0]      table_base;
        logic [VIRTUAL_BITS-1:0] virtual_address;
        logic [ENTRY_BITS-1:0]   entry_data;
    } t_item;

    typedef struct packed {
        logic               result_kind;
        logic [PA_BITS-1:0] read_address;
        logic [PA_BITS-1:0] physical_address;
        logic               fault;
    } t_result;

    typedef struct packed {
        t_level                  level;
        logic [VIRTUAL_BITS-1:0] saved_address;
    } t_walk_state;

endpackage

`default_nettype wire

[hdl/ptw_if.sv]
// valid/ready channel interfaces for walk items and walk results
// depends on ptw_pkg
`default_nettype none

interface ptw_in_if;
    logic                              valid;
    logic                              ready;
    logic                              kind;
    logic [ptw_pkg::PA_BITS-1:0]       table_base;
    logic [ptw_pkg::VIRTUAL_BITS-1:0]  virtual_address;
    logic [ptw_pkg::ENTRY_BITS-1:0]    entry_data;

    modport source (output valid, kind, table_base, virtual_address, entry_data,
                    input ready);
    modport sink   (input valid, kind, table_base, virtual_address, entry_data,
                    output ready);
endinterface

interface ptw_out_if;
    logic                        valid;
    logic                        ready;
    logic                        result_kind;
    logic [ptw_pkg::PA_BITS-1:0] read_address;
    logic [ptw_pkg::PA_BITS-1:0] physical_address;
    logic                        fault;

    modport source (output valid, result_kind, read_address, physical_address, fault,
                    input ready);
    modport sink   (input valid, result_kind, read_address, physical_address, fault,
                    output ready);
endinterface

`default_nettype wire

[hdl/ptw_step.sv]
// one walk step: next walk state and optional result for one item
// depends on ptw_pkg
`default_nettype none

module ptw_step (
    input  var ptw_pkg::t_item       i_item,
    input  var ptw_pkg::t_walk_state i_state,
    output var ptw_pkg::t_walk_state o_state,
    output logic                     o_has_result,
    output var ptw_pkg::t_result     o_result
);

    localparam int IDX_PAD   = ptw_pkg::PA_BITS - ptw_pkg::INDEX_BITS
                               - ptw_pkg::ENTRY_SIZE_BITS;
    localparam int FRAME_PAD = ptw_pkg::PA_BITS - ptw_pkg::FRAME_HI - 1;

    function automatic logic [ptw_pkg::INDEX_BITS-1:0] index_of(
        input ptw_pkg::t_level                  level,
        input logic [ptw_pkg::VIRTUAL_BITS-1:0] va
    );
        logic [ptw_pkg::INDEX_BITS-1:0] idx;
        case (level)
            ptw_pkg::LVL_1: idx = va[ptw_pkg::PAGE_OFFSET_BITS +: ptw_pkg::INDEX_BITS];
            ptw_pkg::LVL_2: idx = va[ptw_pkg::PAGE_OFFSET_BITS
                                     + ptw_pkg::INDEX_BITS +: ptw_pkg::INDEX_BITS];
            ptw_pkg::LVL_3: idx = va[ptw_pkg::PAGE_OFFSET_BITS
                                     + 2 * ptw_pkg::INDEX_BITS +: ptw_pkg::INDEX_BITS];
            ptw_pkg::LVL_4: idx = va[ptw_pkg::PAGE_OFFSET_BITS
                                     + 3 * ptw_pkg::INDEX_BITS +: ptw_pkg::INDEX_BITS];
            default:        idx = '0;
        endcase
        return idx;
    endfunction

    function automatic ptw_pkg::t_level lower_of(input ptw_pkg::t_level level);
        ptw_pkg::t_level nxt;
        case (level)
            ptw_pkg::LVL_4: nxt = ptw_pkg::LVL_3;
            ptw_pkg::LVL_3: nxt = ptw_pkg::LVL_2;
            ptw_pkg::LVL_2: nxt = ptw_pkg::LVL_1;
            default:        nxt = ptw_pkg::LVL_IDLE;
        endcase
        return nxt;
    endfunction

    logic [ptw_pkg::ENTRY_BITS-1:0]   entry;
    logic [ptw_pkg::VIRTUAL_BITS-1:0] sa;
    logic [ptw_pkg::PA_BITS-1:0]      table_base;
    logic [ptw_pkg::PA_BITS-1:0]      next_table;
    logic [ptw_pkg::PA_BITS-1:0]      entry_offset;
    logic [ptw_pkg::FRAME_HI-ptw_pkg::PAGE_OFFSET_BITS:0] frame_4k;
    logic                             present;
    logic                             is_large;
    ptw_pkg::t_level                  lower;

    assign entry      = i_item.entry_data;
    assign sa         = i_state.saved_address;
    assign present    = entry[ptw_pkg::PRESENT_BIT];
    assign is_large   = entry[ptw_pkg::LARGE_BIT];
    assign frame_4k   = entry[ptw_pkg::FRAME_HI:ptw_pkg::PAGE_OFFSET_BITS];
    assign lower      = lower_of(i_state.level);
    assign table_base = {i_item.table_base[ptw_pkg::PA_BITS-1:ptw_pkg::BASE_LOW_BITS],
                         {ptw_pkg::BASE_LOW_BITS{1'b0}}};
    assign next_table = {{FRAME_PAD{1'b0}}, frame_4k,
                         {ptw_pkg::PAGE_OFFSET_BITS{1'b0}}};

    always_comb begin
        o_state      = i_state;
        o_has_result = 1'b0;
        o_result     = '0;
        entry_offset = '0;
        if (i_item.kind == ptw_pkg::KIND_START) begin
            o_state.saved_address = i_item.virtual_address;
            o_state.level         = ptw_pkg::LVL_4;
            o_has_result          = 1'b1;
            entry_offset          = {{IDX_PAD{1'b0}},
                                     index_of(ptw_pkg::LVL_4, i_item.virtual_address),
                                     {ptw_pkg::ENTRY_SIZE_BITS{1'b0}}};
            o_result.result_kind  = ptw_pkg::RES_READ;
            o_result.read_address = table_base + entry_offset;
        end else begin
            case (i_state.level)
                ptw_pkg::LVL_4, ptw_pkg::LVL_3, ptw_pkg::LVL_2, ptw_pkg::LVL_1: begin
                    o_has_result = 1'b1;
                    if (!present) begin
                        o_result.result_kind = ptw_pkg::RES_DONE;
                        o_result.fault       = 1'b1;
                        o_state.level        = ptw_pkg::LVL_IDLE;
                    end else if (i_state.level == ptw_pkg::LVL_3 && is_large) begin
                        o_result.result_kind      = ptw_pkg::RES_DONE;
                        o_result.physical_address =
                            {entry[ptw_pkg::PA_BITS-1:ptw_pkg::PAGE_1G_BITS],
                             sa[ptw_pkg::PAGE_1G_BITS-1:0]};
                        o_state.level             = ptw_pkg::LVL_IDLE;
                    end else if (i_state.level == ptw_pkg::LVL_2 && is_large) begin
                        o_result.result_kind      = ptw_pkg::RES_DONE;
                        o_result.physical_address =
                            {{FRAME_PAD{1'b0}},
                             entry[ptw_pkg::FRAME_HI:ptw_pkg::PAGE_2M_BITS],
                             sa[ptw_pkg::PAGE_2M_BITS-1:0]};
                        o_state.level             = ptw_pkg::LVL_IDLE;
                    end else if (i_state.level == ptw_pkg::LVL_1) begin
                        o_result.result_kind = ptw_pkg::RES_DONE;
                        o_state.level        = ptw_pkg::LVL_IDLE;
                        if (frame_4k == '0) begin
                            o_result.fault = 1'b1;
                        end else begin
                            o_result.physical_address =
                                {{FRAME_PAD{1'b0}}, frame_4k,
                                 sa[ptw_pkg::PAGE_OFFSET_BITS-1:0]};
                        end
                    end else begin
                        o_state.level         = lower;
                        entry_offset          = {{IDX_PAD{1'b0}}, index_of(lower, sa),
                                                 {ptw_pkg::ENTRY_SIZE_BITS{1'b0}}};
                        o_result.result_kind  = ptw_pkg::RES_READ;
                        o_result.read_address = next_table + entry_offset;
                    end
                end
                default: begin
                    o_state.level = ptw_pkg::LVL_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[hdl/page_table_walker.sv]
// Four-level page table walker. Takes one item per cycle on i_req while o_rsp does
// not stall: start items (table base and virtual address) and memory-data items
// (one 8-byte entry each). Each accepted item waits in the input register, then its
// result in the result register; the walk state lives in one register updated by a
// single combinational step, so a stall on o_rsp holds the input register and then
// i_req. A start abandons any walk in progress; data arriving while idle produces no result.
// depends on ptw_pkg, ptw_if, ptw_step
`default_nettype none

module page_table_walker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ptw_in_if.sink      i_req,
    ptw_out_if.source   o_rsp
);

    logic                 r_in_valid;
    ptw_pkg::t_item       r_in;
    ptw_pkg::t_walk_state r_state;
    ptw_pkg::t_walk_state n_state;
    logic                 r_out_valid;
    ptw_pkg::t_result     r_out;
    ptw_pkg::t_result     n_out;
    logic                 has_result;
    logic                 advance;
    logic                 in_take;

    ptw_step u_step (
        .i_item       (r_in),
        .i_state      (r_state),
        .o_state      (n_state),
        .o_has_result (has_result),
        .o_result     (n_out)
    );

    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready || !has_result);
    assign i_req.ready = !r_in_valid || advance;
    assign in_take     = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid            <= 1'b0;
            r_out_valid           <= 1'b0;
            r_state.level         <= ptw_pkg::LVL_IDLE;
            r_state.saved_address <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_state <= n_state;
            end
            if (advance && has_result) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.kind            <= i_req.kind;
            r_in.table_base      <= i_req.table_base;
            r_in.virtual_address <= i_req.virtual_address;
            r_in.entry_data      <= i_req.entry_data;
        end
        if (advance && has_result) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.result_kind      = r_out.result_kind;
    assign o_rsp.read_address     = r_out.read_address;
    assign o_rsp.physical_address = r_out.physical_address;
    assign o_rsp.fault            = r_out.fault;

endmodule

`default_nettype wire

[sim/ptw_checker.sv]
// checker for the page table walker: watches the item and result channels,
// predicts each walk step and compares the results in order
// depends on ptw_pkg and ptw_if
`default_nettype none

module ptw_checker
    import ptw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    ptw_in_if    i_req,
    ptw_out_if   i_rsp,
    output int   o_pending,
    output int   o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    t_level                  walk_lvl = LVL_IDLE;
    logic [VIRTUAL_BITS-1:0] walk_va  = '0;
    t_result                 expected_results[$];
    int                      mismatch_count = 0;

    initial begin
        o_pending    = 0;
        o_mismatches = 0;
    end

    function automatic logic [INDEX_BITS-1:0] table_index(t_level lvl);
        case (lvl)
            LVL_4:   return walk_va[PAGE_OFFSET_BITS + 3*INDEX_BITS +: INDEX_BITS];
            LVL_3:   return walk_va[PAGE_OFFSET_BITS + 2*INDEX_BITS +: INDEX_BITS];
            LVL_2:   return walk_va[PAGE_OFFSET_BITS + INDEX_BITS +: INDEX_BITS];
            default: return walk_va[PAGE_OFFSET_BITS +: INDEX_BITS];
        endcase
    endfunction

    function automatic t_level lower_level(t_level lvl);
        case (lvl)
            LVL_4:   return LVL_3;
            LVL_3:   return LVL_2;
            default: return LVL_1;
        endcase
    endfunction

    function automatic t_result entry_read(logic [PA_BITS-1:0] tbl, t_level lvl);
        t_result r;
        r              = '0;
        r.result_kind  = RES_READ;
        r.read_address = tbl + (PA_BITS'(table_index(lvl)) << ENTRY_SIZE_BITS);
        return r;
    endfunction

    function automatic t_result walk_done(logic [PA_BITS-1:0] pa, logic flt);
        t_result r;
        r                  = '0;
        r.result_kind      = RES_DONE;
        r.physical_address = flt ? '0 : pa;
        r.fault            = flt;
        return r;
    endfunction

    function automatic bit walk_step(input t_item it, output t_result res);
        logic [ENTRY_BITS-1:0] e;
        logic [PA_BITS-1:0]    frame;
        logic [PA_BITS-1:0]    pa;
        e     = it.entry_data;
        res   = '0;
        frame = '0;
        frame[FRAME_HI:PAGE_OFFSET_BITS] = e[FRAME_HI:PAGE_OFFSET_BITS];
        if (it.kind == KIND_START) begin
            walk_va  = it.virtual_address;
            walk_lvl = LVL_4;
            res = entry_read({it.table_base[PA_BITS-1:BASE_LOW_BITS], BASE_LOW_BITS'(0)}, LVL_4);
            return 1'b1;
        end
        if (walk_lvl == LVL_IDLE) begin
            return 1'b0;
        end
        pa = '0;
        if (!e[PRESENT_BIT]) begin
            res      = walk_done('0, 1'b1);
            walk_lvl = LVL_IDLE;
        end else if (walk_lvl == LVL_3 && e[LARGE_BIT]) begin
            pa       = {e[PA_BITS-1:PAGE_1G_BITS], walk_va[PAGE_1G_BITS-1:0]};
            res      = walk_done(pa, 1'b0);
            walk_lvl = LVL_IDLE;
        end else if (walk_lvl == LVL_2 && e[LARGE_BIT]) begin
            pa[FRAME_HI:PAGE_2M_BITS]  = e[FRAME_HI:PAGE_2M_BITS];
            pa[PAGE_2M_BITS-1:0]       = walk_va[PAGE_2M_BITS-1:0];
            res      = walk_done(pa, 1'b0);
            walk_lvl = LVL_IDLE;
        end else if (walk_lvl == LVL_1) begin
            pa       = frame + PA_BITS'(walk_va[PAGE_OFFSET_BITS-1:0]);
            res      = walk_done(pa, frame == '0);
            walk_lvl = LVL_IDLE;
        end else begin
            walk_lvl = lower_level(walk_lvl);
            res      = entry_read(frame, walk_lvl);
        end
        return 1'b1;
    endfunction

    task automatic report_failure(string what, t_result want, t_result got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t %s: expected kind=%0d read=%h phys=%h fault=%0d, got kind=%0d read=%h phys=%h fault=%0d",
                     $realtime, what, want.result_kind, want.read_address,
                     want.physical_address, want.fault, got.result_kind,
                     got.read_address, got.physical_address, got.fault);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_item   accepted;
        t_result got;
        t_result want;
        t_result predicted;
        if (!i_rst_n) begin
            walk_lvl = LVL_IDLE;
            walk_va  = '0;
            expected_results.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                got.result_kind      = i_rsp.result_kind;
                got.read_address     = i_rsp.read_address;
                got.physical_address = i_rsp.physical_address;
                got.fault            = i_rsp.fault;
                if (expected_results.size() == 0) begin
                    report_failure("unexpected result", '0, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got.result_kind !== want.result_kind
                            || got.read_address !== want.read_address
                            || got.physical_address !== want.physical_address
                            || got.fault !== want.fault) begin
                        report_failure("result mismatch", want, got);
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                accepted.kind            = i_req.kind;
                accepted.table_base      = i_req.table_base;
                accepted.virtual_address = i_req.virtual_address;
                accepted.entry_data      = i_req.entry_data;
                if (walk_step(accepted, predicted)) begin
                    expected_results.push_back(predicted);
                end
            end
        end
        o_pending    <= expected_results.size();
        o_mismatches <= mismatch_count;
    end

endmodule

`default_nettype wire

[sim/tb_top.sv]
// testbench top for the page table walker: clock, reset, walk stimulus with
// random gaps and result stalls, and the final verdict
// depends on ptw_pkg, ptw_if, ptw_checker and page_table_walker
`default_nettype none

module tb_top;
    import ptw_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET  = 1150;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 20;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   pending;
    int   mismatches;
    int   items_sent  = 0;
    int   cycle_count = 0;
    int   walk_depth  = 0;
    bit   no_idle;

    ptw_in_if  req_ch();
    ptw_out_if rsp_ch();

    page_table_walker u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    ptw_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [63:0] random_word();
        return {$urandom(), $urandom()};
    endfunction

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [ENTRY_BITS-1:0] pointer_entry();
        logic [ENTRY_BITS-1:0] e;
        e              = random_word();
        e[PRESENT_BIT] = 1'b1;
        e[LARGE_BIT]   = 1'b0;
        return e;
    endfunction

    // mostly well-formed entries: pointers, large leaves, a few faults
    function automatic logic [ENTRY_BITS-1:0] walk_entry(int depth);
        logic [ENTRY_BITS-1:0] e;
        int r;
        e = random_word();
        r = $urandom_range(0, 99);
        e[PRESENT_BIT] = (r >= 8);
        case (depth)
            3: e[LARGE_BIT] = (r < 35);
            2: e[LARGE_BIT] = (r < 40);
            1: begin
                if (r >= 8 && r < 20) begin
                    e[FRAME_HI:PAGE_OFFSET_BITS] = '0;
                end
            end
            default: ;
        endcase
        return e;
    endfunction

    task automatic send_item(t_item it);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(0, 99) >= 55) begin
            gap = idle_length();
        end
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.kind            <= it.kind;
        req_ch.table_base      <= it.table_base;
        req_ch.virtual_address <= it.virtual_address;
        req_ch.entry_data      <= it.entry_data;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_start(logic [PA_BITS-1:0] base, logic [VIRTUAL_BITS-1:0] va);
        t_item it;
        it.kind            = KIND_START;
        it.table_base      = base;
        it.virtual_address = va;
        it.entry_data      = random_word();
        send_item(it);
        items_sent++;
        walk_depth = 4;
    endtask

    task automatic send_entry(logic [ENTRY_BITS-1:0] e);
        t_item it;
        logic [63:0] w;
        w                  = random_word();
        it.kind            = KIND_DATA;
        it.table_base      = w[PA_BITS-1:0];
        it.virtual_address = w[63:64-VIRTUAL_BITS];
        it.entry_data      = e;
        send_item(it);
        if (walk_depth != 0) begin
            items_sent++;
            if (!e[PRESENT_BIT] || walk_depth == 1
                    || (walk_depth != 4 && e[LARGE_BIT])) begin
                walk_depth = 0;
            end else begin
                walk_depth--;
            end
        end
    endtask

    task automatic run_walk(int max_entries);
        logic [63:0] b;
        logic [63:0] v;
        b = random_word();
        v = random_word();
        send_start(b[PA_BITS-1:0], v[VIRTUAL_BITS-1:0]);
        for (int n = 0; n < max_entries && walk_depth != 0; n++) begin
            send_entry(walk_entry(walk_depth));
        end
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin : ready_driver
        int stall_left;
        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (no_idle) begin
                rsp_ch.ready <= 1'b1;
            end else if (stall_left > 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 99) < 65) begin
                rsp_ch.ready <= 1'b1;
            end else begin
                stall_left = idle_length() - 1;
                rsp_ch.ready <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        logic [63:0] w;
        logic [ENTRY_BITS-1:0] e;
        bit paused;
        int r;
        paused = 1'b0;
        i_rst_n                <= 1'b0;
        no_idle                <= 1'b0;
        req_ch.valid           <= 1'b0;
        req_ch.kind            <= KIND_START;
        req_ch.table_base      <= '0;
        req_ch.virtual_address <= '0;
        req_ch.entry_data      <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // data while idle
        send_entry(random_word());
        // all ones; large bit ignored at the top and bottom levels
        send_start('1, '1);
        send_entry('1);
        send_entry(~64'h80);
        send_entry(~64'h80);
        send_entry('1);
        // all zero frames down to a zero 4k frame
        send_start('0, '0);
        repeat (4) send_entry(64'h1);
        // 1g leaf
        w = random_word();
        send_start(w[PA_BITS-1:0], w[63:64-VIRTUAL_BITS]);
        send_entry(pointer_entry());
        send_entry('1);
        // 2m leaf with pat and reserved bits set
        w = random_word();
        send_start(w[63:64-PA_BITS], w[VIRTUAL_BITS-1:0]);
        send_entry(pointer_entry());
        send_entry(pointer_entry());
        send_entry('1);
        // not present at the top
        send_start('1, '0);
        send_entry(~64'h1);
        // start while busy, then not present at level three
        w = random_word();
        send_start(w[PA_BITS-1:0], w[VIRTUAL_BITS-1:0]);
        send_entry(pointer_entry());
        send_start(w[63:64-PA_BITS], w[63:64-VIRTUAL_BITS]);
        send_entry(pointer_entry());
        e = pointer_entry();
        e[PRESENT_BIT] = 1'b0;
        send_entry(e);
        send_entry(random_word());

        drain_results();

        while (items_sent < ITEM_TARGET) begin
            no_idle <= ($urandom_range(0, 9) == 0);
            r = $urandom_range(0, 99);
            if (r < 78) begin
                run_walk(4);
            end else if (r < 92) begin
                run_walk($urandom_range(0, 3));
            end else if (walk_depth == 0) begin
                send_entry(random_word());
            end else begin
                run_walk(4);
            end
            if (!paused && items_sent >= ITEM_TARGET / 2) begin
                drain_results();
                paused = 1'b1;
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
